// ----- hdl/wce_pkg.sv -----
// ----------------------------------------------------------------------------
// wce_pkg
// shared types, constants and functions of the colour frame encoder
// ----------------------------------------------------------------------------
package wce_pkg;

   localparam int MAX_LEDS_DEFAULT      = 16;
   localparam int COLOR_ENTRIES_DEFAULT = 11;
   localparam int NUM_CHANNELS          = 3;

   localparam int INDEX_W     = 4;
   localparam int INTENSITY_W = 7;
   localparam int BYTE_W      = 8;
   localparam int PRODUCT_W   = BYTE_W + INTENSITY_W;
   localparam int WORD_W      = 32;
   localparam int CHANNEL_W   = 2;
   localparam int POSITION_W  = 4;
   localparam int COUNT_W     = 5;

   localparam logic [INTENSITY_W-1:0] FULL_SCALE      = 7'd100;
   localparam logic [COUNT_W-1:0]     LED_COUNT_RESET = 5'd8;

   // x / 100 == (x * 5243) >> 19, exact for x up to 255 * 100
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
   localparam int SCALED_W    = PRODUCT_W + RECIP_W;

   localparam logic [3:0] NIBBLE_ONE  = 4'b0111;
   localparam logic [3:0] NIBBLE_ZERO = 4'b0001;

   typedef enum logic [CHANNEL_W-1:0] {
      CH_GREEN = 2'd0,
      CH_RED   = 2'd1,
      CH_BLUE  = 2'd2
   } channel_type;

   typedef logic [NUM_CHANNELS-1:0][BYTE_W-1:0] grb_type;

   typedef struct packed {
      logic    valid;
      logic    color_ok;
      grb_type bytes;
   } scaled_item_type;

   // returns channel bytes in G, R, B order (index 0 = green)
   function automatic grb_type palette_grb(input logic [INDEX_W-1:0] idx);
      grb_type grb;
      unique case (idx)
         4'd1:    grb = {8'd0,   8'd255, 8'd0};
         4'd2:    grb = {8'd0,   8'd0,   8'd255};
         4'd3:    grb = {8'd255, 8'd0,   8'd0};
         4'd4:    grb = {8'd0,   8'd250, 8'd60};
         4'd5:    grb = {8'd142, 8'd250, 8'd0};
         4'd6:    grb = {8'd73,  8'd110, 8'd250};
         4'd7:    grb = {8'd130, 8'd0,   8'd225};
         4'd8:    grb = {8'd0,   8'd250, 8'd153};
         4'd9:    grb = {8'd102, 8'd250, 8'd191};
         4'd10:   grb = {8'd102, 8'd250, 8'd90};
         default: grb = '0;
      endcase
      return grb;
   endfunction

   // bit 7-j of the byte goes to slot nibble j
   function automatic logic [WORD_W-1:0] line_encode(input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] word;
      word = '0;
      for (int j = 0; j < BYTE_W; j++) begin
         word[4*j +: 4] = b[BYTE_W-1-j] ? NIBBLE_ONE : NIBBLE_ZERO;
      end
      return word;
   endfunction

endpackage

// ----- hdl/wce_scale.sv -----
// ----------------------------------------------------------------------------
// wce_scale
// three stage pipeline: table lookup and clamp, intensity multiply,
// divide by one hundred through a reciprocal multiply
// ----------------------------------------------------------------------------
module wce_scale import wce_pkg::*; #(
   parameter int COLOR_ENTRIES = COLOR_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [INDEX_W-1:0]     color_index,
   input  logic [INTENSITY_W-1:0] intensity,
   input  logic                   out_ready,
   output logic                   in_open,
   output scaled_item_type        item_out
);

   localparam logic [INDEX_W:0] ENTRIES = (INDEX_W+1)'(COLOR_ENTRIES);

   logic                                     s1_valid_ff, s1_valid_in;
   logic                                     s1_ok_ff;
   grb_type                                  s1_bytes_ff;
   logic [INTENSITY_W-1:0]                   s1_inten_ff;

   logic                                     s2_valid_ff, s2_valid_in;
   logic                                     s2_ok_ff;
   logic [NUM_CHANNELS-1:0][PRODUCT_W-1:0]   s2_prod_ff;

   logic                                     s3_valid_ff, s3_valid_in;
   logic                                     s3_ok_ff;
   grb_type                                  s3_bytes_ff;

   logic open1, open2, open3;
   logic [NUM_CHANNELS-1:0][SCALED_W-1:0] scaled;

   // invalid colours leave the last stage without waiting for the emitter
   assign open3 = !s3_valid_ff || out_ready || !s3_ok_ff;
   assign open2 = !s2_valid_ff || open3;
   assign open1 = !s1_valid_ff || open2;
   assign in_open = open1;

   assign s1_valid_in = open1 ? accept : s1_valid_ff;
   assign s2_valid_in = open2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = open3 ? s2_valid_ff : s3_valid_ff;

   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         scaled[k] = SCALED_W'(s2_prod_ff[k]) * SCALED_W'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (open1) begin
         s1_ok_ff    <= ({1'b0, color_index} < ENTRIES);
         s1_bytes_ff <= palette_grb(color_index);
         s1_inten_ff <= (intensity > FULL_SCALE) ? FULL_SCALE : intensity;
      end
      if (open2) begin
         s2_ok_ff <= s1_ok_ff;
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            s2_prod_ff[k] <= PRODUCT_W'(s1_bytes_ff[k]) * PRODUCT_W'(s1_inten_ff);
         end
      end
      if (open3) begin
         s3_ok_ff <= s2_ok_ff;
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            s3_bytes_ff[k] <= scaled[k][RECIP_SHIFT +: BYTE_W];
         end
      end
   end

   assign item_out.valid    = s3_valid_ff;
   assign item_out.color_ok = s3_ok_ff;
   assign item_out.bytes    = s3_bytes_ff;

endmodule

// ----- hdl/wce_emit.sv -----
// ----------------------------------------------------------------------------
// wce_emit
// line-codes the three channel bytes and repeats the three words once per led
// ----------------------------------------------------------------------------
module wce_emit import wce_pkg::*; #(
   parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scaled_item_type       item_in,
   input  logic [COUNT_W-1:0]    led_count,
   output logic                  ready,
   output logic                  strobe,
   output logic [WORD_W-1:0]     line_word,
   output logic [CHANNEL_W-1:0]  channel,
   output logic [POSITION_W-1:0] led_position,
   output logic                  after_reset,
   output logic                  last
);

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_LEDS);

   logic                                  active_ff, active_in;
   logic                                  first_ff, first_in;
   channel_type                           ch_ff, ch_in;
   logic [POSITION_W-1:0]                 pos_ff, pos_in;
   logic [POSITION_W-1:0]                 last_pos_ff, last_pos_in;
   logic [NUM_CHANNELS-1:0][WORD_W-1:0]   words_ff;

   logic                 last_word;
   logic                 load;
   logic [COUNT_W-1:0]   count_sat;
   logic                 count_zero;

   assign count_sat  = (led_count > MAX_COUNT) ? MAX_COUNT : led_count;
   assign count_zero = (count_sat == '0);
   assign last_word  = active_ff && (ch_ff == CH_BLUE) && (pos_ff == last_pos_ff);
   assign ready      = !active_ff || last_word;
   assign load       = ready && item_in.valid && item_in.color_ok && !count_zero;

   always_comb begin
      active_in   = active_ff;
      first_in    = first_ff;
      ch_in       = ch_ff;
      pos_in      = pos_ff;
      last_pos_in = last_pos_ff;
      if (load) begin
         active_in   = 1'b1;
         first_in    = 1'b1;
         ch_in       = CH_GREEN;
         pos_in      = '0;
         last_pos_in = POSITION_W'(count_sat - COUNT_W'(1));
      end else if (last_word) begin
         active_in = 1'b0;
         first_in  = 1'b0;
      end else if (active_ff) begin
         first_in = 1'b0;
         unique case (ch_ff)
            CH_GREEN: ch_in = CH_RED;
            CH_RED:   ch_in = CH_BLUE;
            default: begin
               ch_in  = CH_GREEN;
               pos_in = pos_ff + POSITION_W'(1);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         first_ff  <= 1'b0;
         ch_ff     <= CH_GREEN;
         pos_ff    <= '0;
      end else begin
         active_ff <= active_in;
         first_ff  <= first_in;
         ch_ff     <= ch_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      last_pos_ff <= last_pos_in;
      if (load) begin
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            words_ff[k] <= line_encode(item_in.bytes[k]);
         end
      end
   end

   assign strobe       = active_ff;
   assign line_word    = words_ff[ch_ff];
   assign channel      = ch_ff;
   assign led_position = pos_ff;
   assign after_reset  = first_ff;
   assign last         = last_word;

endmodule

// ----- hdl/ws2812_color_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// ws2812_color_frame_encoder
// scales a palette colour by intensity and sends the line-coded g, r, b words
// once per led of the chain
//
//   port group  direction  handshake
//   req_        in         start high and busy low
//   rsp_        out        rsp_strobe marks each word, no back-pressure
//   csr_        in         csr_valid and csr_ready (always ready)
//
// a valid item gives 3 * led_count words (led_count capped at MAX_LEDS), one
// per cycle. the word emitter sets the sustained rate: it takes a new item only
// when idle or as the last word of the one before goes out. three items can
// wait in the scaling pipeline while words go out; busy rises when it is full
// and stalled. items with an invalid colour or a zero led count pass through
// and give no words. reset clears all valid bits and sets led_count to 8.
// ----------------------------------------------------------------------------
module ws2812_color_frame_encoder import wce_pkg::*; #(
   parameter int MAX_LEDS      = MAX_LEDS_DEFAULT,
   parameter int COLOR_ENTRIES = COLOR_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [INDEX_W-1:0]     req_color_index,
   input  logic [INTENSITY_W-1:0] req_intensity,
   output logic                   rsp_strobe,
   output logic [WORD_W-1:0]      rsp_line_word,
   output logic [CHANNEL_W-1:0]   rsp_channel,
   output logic [POSITION_W-1:0]  rsp_led_position,
   output logic                   rsp_after_reset,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [COUNT_W-1:0]     csr_led_count
);

   logic [COUNT_W-1:0] led_count_ff, led_count_in;
   logic               in_open;
   logic               accept;
   logic               emit_ready;
   scaled_item_type    scaled_item;

   assign csr_ready    = 1'b1;
   assign led_count_in = (csr_valid && csr_ready) ? csr_led_count : led_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= LED_COUNT_RESET;
      end else begin
         led_count_ff <= led_count_in;
      end
   end

   assign busy   = !in_open;
   assign accept = start && !busy;

   wce_scale #(
      .COLOR_ENTRIES (COLOR_ENTRIES)
   ) u_scale (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .color_index (req_color_index),
      .intensity   (req_intensity),
      .out_ready   (emit_ready),
      .in_open     (in_open),
      .item_out    (scaled_item)
   );

   wce_emit #(
      .MAX_LEDS (MAX_LEDS)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .item_in      (scaled_item),
      .led_count    (led_count_ff),
      .ready        (emit_ready),
      .strobe       (rsp_strobe),
      .line_word    (rsp_line_word),
      .channel      (rsp_channel),
      .led_position (rsp_led_position),
      .after_reset  (rsp_after_reset),
      .last         (rsp_last)
   );

endmodule

// ----- dv/ws2812_color_frame_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// ws2812_color_frame_encoder_tb
// self-checking testbench of the colour frame encoder
//
// drives colour requests through the start/busy handshake and sets the led
// count through the csr channel while the block is idle. a local model scales
// the palette colour, line-codes the g, r, b bytes and queues the words of
// each frame; every rsp_strobe word is checked field by field against the
// oldest queued word. directed tests cover the palette, the intensity limits,
// invalid colours and the led count limits, then random phases follow.
// ----------------------------------------------------------------------------
module ws2812_color_frame_encoder_tb import wce_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          NUM_COLORS   = 11;
   localparam int          CHAIN_MAX    = 16;
   localparam int          PERCENT_MAX  = 100;
   localparam logic [3:0]  SLOT_ONE     = 4'b0111;
   localparam logic [3:0]  SLOT_ZERO    = 4'b0001;
   localparam int          DRAIN_CYCLES = 24;
   localparam longint      CYCLE_LIMIT  = 400000;

   typedef struct {
      logic [WORD_W-1:0]     line_word;
      channel_type           channel;
      logic [POSITION_W-1:0] led_position;
      logic                  after_reset;
      logic                  last;
   } led_word_type;

   logic                   clock;
   logic                   reset           = 1'b1;
   logic                   start           = 1'b0;
   logic                   busy;
   logic [INDEX_W-1:0]     req_color_index = '0;
   logic [INTENSITY_W-1:0] req_intensity   = '0;
   logic                   rsp_strobe;
   logic [WORD_W-1:0]      rsp_line_word;
   logic [CHANNEL_W-1:0]   rsp_channel;
   logic [POSITION_W-1:0]  rsp_led_position;
   logic                   rsp_after_reset;
   logic                   rsp_last;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   logic [COUNT_W-1:0]     csr_led_count   = '0;

   led_word_type       pending_words[$];
   logic [COUNT_W-1:0] chain_length = LED_COUNT_RESET;
   bit                 gapless      = 1'b0;
   int                 mismatches   = 0;
   longint             cycles       = 0;

   ws2812_color_frame_encoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_color_index  (req_color_index),
      .req_intensity    (req_intensity),
      .rsp_strobe       (rsp_strobe),
      .rsp_line_word    (rsp_line_word),
      .rsp_channel      (rsp_channel),
      .rsp_led_position (rsp_led_position),
      .rsp_after_reset  (rsp_after_reset),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_led_count    (csr_led_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // palette entry as {red, green, blue}
   function automatic logic [23:0] color_rgb(input logic [INDEX_W-1:0] idx);
      case (idx)
         4'd1:    return {8'd255, 8'd0,   8'd0};
         4'd2:    return {8'd0,   8'd255, 8'd0};
         4'd3:    return {8'd0,   8'd0,   8'd255};
         4'd4:    return {8'd250, 8'd60,  8'd0};
         4'd5:    return {8'd250, 8'd0,   8'd142};
         4'd6:    return {8'd110, 8'd250, 8'd73};
         4'd7:    return {8'd0,   8'd225, 8'd130};
         4'd8:    return {8'd250, 8'd153, 8'd0};
         4'd9:    return {8'd250, 8'd191, 8'd102};
         4'd10:   return {8'd250, 8'd90,  8'd102};
         default: return 24'd0;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] slot_word(input int level, input int percent);
      logic [7:0]        scaled;
      logic [WORD_W-1:0] word;
      scaled = 8'((level * percent) / PERCENT_MAX);
      word   = '0;
      for (int j = 0; j < 8; j++) begin
         word[4*j +: 4] = scaled[7-j] ? SLOT_ONE : SLOT_ZERO;
      end
      return word;
   endfunction

   task automatic predict_frame(input logic [INDEX_W-1:0] idx,
                                input logic [INTENSITY_W-1:0] inten);
      logic [23:0]       rgb;
      int                percent;
      int                leds;
      int                total;
      int                n;
      logic [WORD_W-1:0] grb_words[3];
      led_word_type      w;
      if (idx >= NUM_COLORS) return;
      percent = (inten > PERCENT_MAX) ? PERCENT_MAX : int'(inten);
      leds    = (chain_length > CHAIN_MAX) ? CHAIN_MAX : int'(chain_length);
      if (leds == 0) return;
      rgb          = color_rgb(idx);
      grb_words[0] = slot_word(rgb[15:8], percent);
      grb_words[1] = slot_word(rgb[23:16], percent);
      grb_words[2] = slot_word(rgb[7:0], percent);
      total = 3 * leds;
      n     = 0;
      for (int r = 0; r < leds; r++) begin
         for (int k = 0; k < 3; k++) begin
            w.line_word    = grb_words[k];
            w.channel      = channel_type'(k);
            w.led_position = POSITION_W'(r);
            w.after_reset  = (n == 0);
            w.last         = (n + 1 == total);
            pending_words.push_back(w);
            n++;
         end
      end
   endtask

   always @(posedge clock) begin
      led_word_type w;
      if (!reset && rsp_strobe) begin
         if (pending_words.size() == 0) begin
            $error("unexpected word: line_word %h channel %0d", rsp_line_word, rsp_channel);
            mismatches++;
         end else begin
            w = pending_words.pop_front();
            if (rsp_line_word !== w.line_word) begin
               $error("line_word: expected %h, got %h", w.line_word, rsp_line_word);
               mismatches++;
            end
            if (rsp_channel !== w.channel) begin
               $error("channel: expected %0d, got %0d", w.channel, rsp_channel);
               mismatches++;
            end
            if (rsp_led_position !== w.led_position) begin
               $error("led_position: expected %0d, got %0d", w.led_position,
                      rsp_led_position);
               mismatches++;
            end
            if (rsp_after_reset !== w.after_reset) begin
               $error("after_reset: expected %b, got %b", w.after_reset, rsp_after_reset);
               mismatches++;
            end
            if (rsp_last !== w.last) begin
               $error("last: expected %b, got %b", w.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   task automatic send_color(input logic [INDEX_W-1:0] idx,
                             input logic [INTENSITY_W-1:0] inten);
      int gap;
      gap = gapless ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_color_index <= idx;
      req_intensity   <= inten;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_frame(idx, inten);
   endtask

   task automatic drain_frames();
      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_led_count(input logic [COUNT_W-1:0] value);
      drain_frames();
      csr_valid     <= 1'b1;
      csr_led_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      chain_length = value;
      csr_valid <= 1'b0;
   endtask

   // full palette at the reset led count
   task automatic test_palette();
      for (int i = 0; i < NUM_COLORS; i++) begin
         send_color(INDEX_W'(i), 7'd100);
      end
   endtask

   task automatic test_intensity();
      send_color(4'd9, 7'd0);
      send_color(4'd9, 7'd1);
      send_color(4'd9, 7'd99);
      send_color(4'd6, 7'd101);
      send_color(4'd6, 7'd127);
   endtask

   task automatic test_invalid_color();
      send_color(4'd11, 7'd100);
      send_color(4'd15, 7'd127);
      send_color(4'd12, 7'd0);
   endtask

   // one item each at the chain limits, saturation and zero length
   task automatic test_led_count();
      logic [COUNT_W-1:0] counts[5];
      counts = '{5'd1, 5'd16, 5'd17, 5'd31, 5'd0};
      foreach (counts[i]) begin
         write_led_count(counts[i]);
         send_color(INDEX_W'($urandom_range(1, 10)), INTENSITY_W'($urandom_range(0, 127)));
      end
   endtask

   task automatic test_random_frames();
      int                     pick;
      logic [COUNT_W-1:0]     leds;
      logic [INDEX_W-1:0]     idx;
      logic [INTENSITY_W-1:0] inten;
      for (int phase = 0; phase < 10; phase++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)      leds = 5'd0;
         else if (pick == 1) leds = COUNT_W'($urandom_range(17, 31));
         else                leds = COUNT_W'($urandom_range(1, 16));
         write_led_count(leds);
         gapless = ($urandom_range(0, 3) == 0);
         repeat (50) begin
            if ($urandom_range(0, 99) < 85) idx = INDEX_W'($urandom_range(0, 10));
            else                            idx = INDEX_W'($urandom_range(11, 15));
            if ($urandom_range(0, 99) < 80) inten = INTENSITY_W'($urandom_range(0, 100));
            else                            inten = INTENSITY_W'($urandom_range(101, 127));
            send_color(idx, inten);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_palette();
      gapless = 1'b1;
      test_intensity();
      gapless = 1'b0;
      test_invalid_color();
      test_led_count();
      test_random_frames();
      drain_frames();
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/wce_pkg.sv
hdl/wce_scale.sv
hdl/wce_emit.sv
hdl/ws2812_color_frame_encoder.sv
dv/ws2812_color_frame_encoder_tb.sv
